// ===== sv/mbbs_pkg.sv =====
package mbbs_pkg;

	localparam int unsigned CoordW = 12;
	localparam int unsigned ValueW = 8;
	localparam int unsigned PosW   = 14;
	localparam int unsigned SizeW  = 13;

	localparam int unsigned InDataW  = 32;
	localparam int unsigned OutDataW = 56;

	// Merged extremes of one finished frame.
	typedef struct packed {
		logic              empty;
		logic [CoordW-1:0] row_min;
		logic [CoordW-1:0] row_max;
		logic [CoordW-1:0] col_min;
		logic [CoordW-1:0] col_max;
	} box_t;

endpackage

// ===== sv/mask_bounding_box_square.sv =====
// Channel   | Direction | Contents
// s_axis    | in        | one mask pixel request: value, row, column; tlast ends the frame
// m_axis    | out       | one crop rectangle per frame; tuser flags an empty mask
// cfg       | in        | fixed_aspect register write
//
// One pixel is accepted every cycle while s_tready is high; the min/max compare is a single stage.
// The rectangle of a frame is registered in the middle stage, then in the output register.
// Reset clears the tracked extremes and sets fixed_aspect to 1.
// A stalled output holds the result and one frame end in the middle stage;
// no pixel is accepted while that stage is full and the output is stalled.
module mask_bounding_box_square #(
	parameter int unsigned MAX_DIM = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [7:0] mask_value, [19:8] pixel_row, [31:20] pixel_col
	input  logic [mbbs_pkg::InDataW-1:0]      s_tdata,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [13:0] box_x, [27:14] box_y, [40:28] box_width, [53:41] box_height, [55:54] zero
	output logic [mbbs_pkg::OutDataW-1:0]     m_tdata,
	// [0] box_empty
	output logic                              m_tuser,
	input  logic                              cfg_we,
	input  logic                              cfg_wdata
);

	logic                              fixed_aspect_q;
	logic                              take;
	logic                              advance;
	logic                              box_valid_s1;
	mbbs_pkg::box_t                    box_s1;
	logic signed [mbbs_pkg::PosW-1:0]  box_x, box_y;
	logic [mbbs_pkg::SizeW-1:0]        box_width, box_height;

	assign take = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_aspect_q <= 1'b1;
		end else if (cfg_we) begin
			fixed_aspect_q <= cfg_wdata;
		end
	end

	mbbs_tracker #(
		.MAX_DIM(MAX_DIM)
	) u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.mask_value  (s_tdata[7:0]),
		.pixel_row   (s_tdata[19:8]),
		.pixel_col   (s_tdata[31:20]),
		.end_of_frame(s_tlast),
		.advance     (advance),
		.ready       (s_tready),
		.box_valid_s1(box_valid_s1),
		.box_s1      (box_s1)
	);

	mbbs_shaper u_shaper (
		.clk         (clk),
		.arst_n      (arst_n),
		.fixed_aspect(fixed_aspect_q),
		.box_valid_s1(box_valid_s1),
		.box_s1      (box_s1),
		.out_ready   (m_tready),
		.advance     (advance),
		.out_valid_q (m_tvalid),
		.box_x_q     (box_x),
		.box_y_q     (box_y),
		.box_width_q (box_width),
		.box_height_q(box_height),
		.box_empty_q (m_tuser)
	);

	assign m_tdata = {2'b00, box_height, box_width, box_y, box_x};

endmodule

// ===== sv/mbbs_tracker.sv =====
module mbbs_tracker #(
	parameter int unsigned MAX_DIM = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             take,
	input  logic [mbbs_pkg::ValueW-1:0]      mask_value,
	input  logic [mbbs_pkg::CoordW-1:0]      pixel_row,
	input  logic [mbbs_pkg::CoordW-1:0]      pixel_col,
	input  logic                             end_of_frame,
	input  logic                             advance,
	output logic                             ready,
	output logic                             box_valid_s1,
	output mbbs_pkg::box_t                   box_s1
);

	localparam logic [31:0] DimLimit = 32'(MAX_DIM);

	logic [mbbs_pkg::CoordW-1:0] row_min_q, row_max_q, col_min_q, col_max_q;
	logic                        any_set_q;
	logic [mbbs_pkg::CoordW-1:0] row_min_n, row_max_n, col_min_n, col_max_n;
	logic                        any_set_n;
	logic                        hit;

	assign ready = !box_valid_s1 || advance;

	always_comb begin
		hit = (mask_value != '0)
			&& ({20'd0, pixel_row} < DimLimit)
			&& ({20'd0, pixel_col} < DimLimit);
		row_min_n = (hit && pixel_row < row_min_q) ? pixel_row : row_min_q;
		row_max_n = (hit && pixel_row > row_max_q) ? pixel_row : row_max_q;
		col_min_n = (hit && pixel_col < col_min_q) ? pixel_col : col_min_q;
		col_max_n = (hit && pixel_col > col_max_q) ? pixel_col : col_max_q;
		any_set_n = any_set_q || hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_min_q <= '1;
			row_max_q <= '0;
			col_min_q <= '1;
			col_max_q <= '0;
			any_set_q <= 1'b0;
		end else if (take) begin
			if (end_of_frame) begin
				// The frame is closed: start the next one from the reset values.
				row_min_q <= '1;
				row_max_q <= '0;
				col_min_q <= '1;
				col_max_q <= '0;
				any_set_q <= 1'b0;
			end else begin
				row_min_q <= row_min_n;
				row_max_q <= row_max_n;
				col_min_q <= col_min_n;
				col_max_q <= col_max_n;
				any_set_q <= any_set_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_valid_s1 <= 1'b0;
		end else if (take && end_of_frame) begin
			box_valid_s1 <= 1'b1;
		end else if (advance) begin
			box_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && end_of_frame) begin
			box_s1.empty   <= !any_set_n;
			box_s1.row_min <= row_min_n;
			box_s1.row_max <= row_max_n;
			box_s1.col_min <= col_min_n;
			box_s1.col_max <= col_max_n;
		end
	end

endmodule

// ===== sv/mbbs_shaper.sv =====
module mbbs_shaper (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fixed_aspect,
	input  logic                            box_valid_s1,
	input  mbbs_pkg::box_t                  box_s1,
	input  logic                            out_ready,
	output logic                            advance,
	output logic                            out_valid_q,
	output logic signed [mbbs_pkg::PosW-1:0] box_x_q,
	output logic signed [mbbs_pkg::PosW-1:0] box_y_q,
	output logic [mbbs_pkg::SizeW-1:0]      box_width_q,
	output logic [mbbs_pkg::SizeW-1:0]      box_height_q,
	output logic                            box_empty_q
);

	logic [mbbs_pkg::SizeW-1:0] rows, cols, diff, half, grow;
	logic                       cols_longer;
	logic [mbbs_pkg::PosW-1:0]  x_n, y_n;
	logic [mbbs_pkg::SizeW-1:0] w_n, h_n;

	assign advance = !out_valid_q || out_ready;

	always_comb begin
		rows = {1'b0, box_s1.row_max} - {1'b0, box_s1.row_min} + 13'd1;
		cols = {1'b0, box_s1.col_max} - {1'b0, box_s1.col_min} + 13'd1;
		cols_longer = cols > rows;
		diff = cols_longer ? (cols - rows) : (rows - cols);
		half = fixed_aspect ? (diff >> 1) : '0;
		grow = {half[mbbs_pkg::SizeW-2:0], 1'b0};
		x_n = {2'b00, box_s1.col_min};
		y_n = {2'b00, box_s1.row_min};
		w_n = cols;
		h_n = rows;
		// Widen the shorter side when fixed_aspect is set; a tie widens the column side by zero.
		if (cols_longer) begin
			y_n = y_n - {1'b0, half};
			h_n = rows + grow;
		end else begin
			x_n = x_n - {1'b0, half};
			w_n = cols + grow;
		end
		if (box_s1.empty) begin
			x_n = '0;
			y_n = '0;
			w_n = '0;
			h_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= box_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && box_valid_s1) begin
			box_x_q      <= x_n;
			box_y_q      <= y_n;
			box_width_q  <= w_n;
			box_height_q <= h_n;
			box_empty_q  <= box_s1.empty;
		end
	end

endmodule
